// ===== rtl/pfi_pkg.sv =====
// Shared types, codes and the preset color table for the palette find-or-insert block.
// No dependencies; the controller, the datapath and the top level import it.
package pfi_pkg;

	// default geometry
	localparam int DEF_PALETTE_SIZE = 256;
	localparam int DEF_PRESET_COUNT = 16;

	// operation codes
	localparam logic OP_MAP    = 1'b0;
	localparam logic OP_REINIT = 1'b1;

	// configuration register indexes
	localparam logic CFG_SKIP_ZERO       = 1'b0;
	localparam logic CFG_FILL_FROM_START = 1'b1;

	// input word
	typedef struct packed {
		logic       op;
		logic [7:0] pixel_index;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} item_t;

	// result word
	typedef struct packed {
		logic [7:0] mapped_index;
		logic       was_added;
		logic       palette_full;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic load;          // capture the item color and set up the scan counter
		logic step;          // issue one palette read and advance the counter
		logic reinit;        // restore preset cursors
		logic respond_zero;  // all-zero result
		logic respond_hit;   // result from the matching entry
		logic respond_miss;  // insert or flag full
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic reinit_op;
		logic transparent;
		logic hit;
		logic scan_end;
		logic in_flight;
	} status_t;

	// fixed preset colors, red in the top byte
	function automatic logic [23:0] preset_rgb(input logic [3:0] idx);
		logic [23:0] c;
		case (idx)
			4'd0:    c = 24'h000000;
			4'd1:    c = 24'h0000AB;
			4'd2:    c = 24'h00AB00;
			4'd3:    c = 24'h00ABAB;
			4'd4:    c = 24'hAB0000;
			4'd5:    c = 24'hAB00AB;
			4'd6:    c = 24'hAB5700;
			4'd7:    c = 24'hABABAB;
			4'd8:    c = 24'h575757;
			4'd9:    c = 24'h5757FF;
			4'd10:   c = 24'h57FF57;
			4'd11:   c = 24'h57FFFF;
			4'd12:   c = 24'hFF5757;
			4'd13:   c = 24'hFF57FF;
			4'd14:   c = 24'hFFFF57;
			default: c = 24'hFFFFFF;
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/pfi_ctrl.sv =====
// Controller state machine for the palette find-or-insert block.
// Depends on pfi_pkg for the command and status structs.
module pfi_ctrl
	import pfi_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  status_t status,
	output cmd_t    cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	logic state_q;
	logic state_d;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (status.reinit_op) begin
						cmd.reinit       = 1'b1;
						cmd.respond_zero = 1'b1;
					end else if (status.transparent) begin
						cmd.respond_zero = 1'b1;
					end else begin
						cmd.load = 1'b1;
						state_d  = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (status.hit) begin
					cmd.respond_hit = 1'b1;
					state_d         = ST_IDLE;
				end else if (status.scan_end && !status.in_flight) begin
					cmd.respond_miss = 1'b1;
					state_d          = ST_IDLE;
				end else begin
					cmd.step = !status.scan_end;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule

// ===== rtl/pfi_datapath.sv =====
// Datapath: palette memory, cursors, scan counter, compare and result register.
// Depends on pfi_pkg for word types, command/status structs and the preset table.
module pfi_datapath
	import pfi_pkg::*;
#(
	parameter int PALETTE_SIZE = DEF_PALETTE_SIZE,
	parameter int PRESET_COUNT = DEF_PRESET_COUNT
) (
	input  logic    clk,
	input  logic    arst_n,
	input  item_t   item,
	input  logic    cfg_we,
	input  logic    cfg_index,
	input  logic    cfg_data,
	input  cmd_t    cmd,
	output status_t status,
	output logic    done,
	output result_t result
);

	localparam int AW = $clog2(PALETTE_SIZE);
	localparam int CW = $clog2(PALETTE_SIZE + 1);

	logic          skip_zero_q;
	logic          fill_q;
	logic [CW-1:0] low_q;
	logic [CW-1:0] high_q;
	logic [CW-1:0] cnt_q;
	logic [23:0]   rgb_q;

	logic [23:0]   mem [PALETTE_SIZE];

	logic          rv_s1;
	logic [AW-1:0] raddr_s1;
	logic [23:0]   rd_s1;
	logic [23:0]   preset_s1;
	logic          is_preset_s1;

	logic          done_q;
	result_t       result_q;

	logic [CW-1:0] cnt_dec;
	logic [CW-1:0] high_dec;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] ins_addr;
	logic [23:0]   entry;
	logic          full;

	// scan address: up from 0 in the low region, down from the top otherwise
	assign cnt_dec  = cnt_q - CW'(1);
	assign high_dec = high_q - CW'(1);
	assign rd_addr  = fill_q ? cnt_q[AW-1:0] : cnt_dec[AW-1:0];
	assign ins_addr = fill_q ? low_q[AW-1:0] : high_dec[AW-1:0];
	assign full     = (low_q >= high_q);

	// entry under compare: presets come from the constant table
	assign entry = is_preset_s1 ? preset_s1 : rd_s1;

	assign status.reinit_op   = (item.op == OP_REINIT);
	assign status.transparent = skip_zero_q && (item.pixel_index == 8'd0);
	assign status.hit         = rv_s1 && (entry == rgb_q);
	assign status.scan_end    = fill_q ? (cnt_q == low_q) : (cnt_q == high_q);
	assign status.in_flight   = rv_s1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_zero_q <= 1'b0;
			fill_q      <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SKIP_ZERO:       skip_zero_q <= cfg_data;
				CFG_FILL_FROM_START: fill_q      <= cfg_data;
			endcase
		end
	end

	// region cursors
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= CW'(PRESET_COUNT);
			high_q <= CW'(PALETTE_SIZE);
		end else if (cmd.reinit) begin
			low_q  <= CW'(PRESET_COUNT);
			high_q <= CW'(PALETTE_SIZE);
		end else if (cmd.respond_miss && !full) begin
			if (fill_q) begin
				low_q <= low_q + CW'(1);
			end else begin
				high_q <= high_dec;
			end
		end
	end

	// scan counter and captured color
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rgb_q <= {item.red, item.green, item.blue};
			cnt_q <= fill_q ? '0 : CW'(PALETTE_SIZE);
		end else if (cmd.step) begin
			cnt_q <= fill_q ? (cnt_q + CW'(1)) : cnt_dec;
		end
	end

	// palette memory: one registered read, one write on insert
	always_ff @(posedge clk) begin
		if (cmd.respond_miss && !full) begin
			mem[ins_addr] <= rgb_q;
		end
		rd_s1        <= mem[rd_addr];
		preset_s1    <= preset_rgb(rd_addr[3:0]);
		is_preset_s1 <= (int'(rd_addr) < PRESET_COUNT);
		raddr_s1     <= rd_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_s1 <= 1'b0;
		end else begin
			rv_s1 <= cmd.step;
		end
	end

	// result word, shown for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.respond_zero || cmd.respond_hit || cmd.respond_miss;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.respond_zero) begin
			result_q <= '0;
		end else if (cmd.respond_hit) begin
			result_q.mapped_index <= 8'(raddr_s1);
			result_q.was_added    <= 1'b0;
			result_q.palette_full <= 1'b0;
		end else if (cmd.respond_miss) begin
			result_q.mapped_index <= full ? 8'd0 : 8'(ins_addr);
			result_q.was_added    <= !full;
			result_q.palette_full <= full;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== rtl/palette_find_or_insert.sv =====
// Top level of the palette find-or-insert block: controller plus datapath.
// Depends on pfi_pkg, pfi_ctrl and pfi_datapath.
//
// Usage: pulse start with an item while busy is low. A reinitialise or a transparent
// pixel never raises busy; its result appears with done on the next cycle. A map item
// scans its palette region one entry per cycle through the single read port of the
// palette memory, with the compare in the cycle after the read; busy stays high until
// the color matches an entry scanned or, on a miss, the whole region has been scanned.
// The result shows with done for exactly one cycle right after busy falls; the
// receiver cannot stall it, and a new item may be started in that same cycle.
// Configuration writes are always ready and are meant to be made only while idle.
module palette_find_or_insert
	import pfi_pkg::*;
#(
	parameter int PALETTE_SIZE = DEF_PALETTE_SIZE,
	parameter int PRESET_COUNT = DEF_PRESET_COUNT
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  item_t   item,
	input  logic    cfg_valid,
	output logic    cfg_ready,
	input  logic    cfg_index,
	input  logic    cfg_data,
	output logic    done,
	output result_t result
);

	cmd_t    cmd;
	status_t status;

	assign cfg_ready = 1'b1;

	pfi_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.status (status),
		.cmd    (cmd)
	);

	pfi_datapath #(
		.PALETTE_SIZE (PALETTE_SIZE),
		.PRESET_COUNT (PRESET_COUNT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.done      (done),
		.result    (result)
	);

endmodule

// ===== tb/tb_palette_find_or_insert.sv =====
// Self-checking testbench for palette_find_or_insert: directed table, then random words.
// Depends on pfi_pkg and the palette_find_or_insert RTL; holds its own palette model.
`timescale 1ns / 1ps

module tb_palette_find_or_insert;
	import pfi_pkg::*;

	localparam int CYCLE_LIMIT   = 2_000_000;
	localparam int DRAIN_CYCLES  = 300;   // longer than one full scan plus the result cycle
	localparam int SEG_COUNT     = 8;
	localparam int SEG_WORDS     = 128;
	localparam int DIR_ROWS      = 21;

	// per-segment register settings, bit n belongs to segment n
	localparam bit [7:0] SEG_SKIP = 8'b1010_1100;
	localparam bit [7:0] SEG_FILL = 8'b0110_0101;

	localparam logic [23:0] PRESET_COLORS [16] = '{
		24'h000000, 24'h0000AB, 24'h00AB00, 24'h00ABAB,
		24'hAB0000, 24'hAB00AB, 24'hAB5700, 24'hABABAB,
		24'h575757, 24'h5757FF, 24'h57FF57, 24'h57FFFF,
		24'hFF5757, 24'hFF57FF, 24'hFFFF57, 24'hFFFFFF
	};

	typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_e;

	typedef struct {
		row_kind_e   kind;
		logic        cfg_idx;
		logic        cfg_val;
		logic        op;
		logic [7:0]  pix;
		logic [23:0] rgb;
		bit          typed;
		logic [7:0]  e_idx;
		logic        e_add;
		logic        e_full;
	} dir_row_t;

	// DUT connections, all inputs known from time zero
	logic    clk       = 1'b0;
	logic    arst_n    = 1'b0;
	logic    start     = 1'b0;
	item_t   item      = '0;
	logic    cfg_valid = 1'b0;
	logic    cfg_index = CFG_SKIP_ZERO;
	logic    cfg_data  = 1'b0;
	logic    busy;
	logic    cfg_ready;
	logic    done;
	result_t result;

	// palette model state
	logic [23:0] pal_model [256];
	logic [8:0]  low_cur;
	logic [8:0]  high_cur;
	logic        skip_zero_r;
	logic        fill_start_r;

	result_t     pending_maps [$];
	result_t     oldest_map;
	int          mismatch_count = 0;
	int          cycle_count    = 0;
	dir_row_t    dir_rows [DIR_ROWS];

	palette_find_or_insert i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.done      (done),
		.result    (result)
	);

	always #6 clk = ~clk;

	// presets back in, cursors to their reset values
	function automatic void restore_presets();
		for (int i = 0; i < 256; i++) begin
			pal_model[i] = (i < 16) ? PRESET_COLORS[i] : 24'h000000;
		end
		low_cur  = 9'd16;
		high_cur = 9'd256;
	endfunction

	// find-or-insert on the model; updates the palette and cursors
	function automatic result_t predict_mapping(input item_t w);
		result_t     r;
		logic [23:0] rgb;
		bit          hit;
		r   = '0;
		rgb = {w.red, w.green, w.blue};
		hit = 1'b0;
		if (w.op == OP_REINIT) begin
			restore_presets();
		end else if (skip_zero_r && w.pixel_index == 8'd0) begin
			r = '0;
		end else begin
			if (fill_start_r) begin
				for (int i = 0; i < int'(low_cur) && i < 256; i++) begin
					if (pal_model[i] == rgb) begin
						r.mapped_index = 8'(i);
						hit = 1'b1;
						break;
					end
				end
			end else begin
				for (int i = 255; i >= int'(high_cur); i--) begin
					if (pal_model[i] == rgb) begin
						r.mapped_index = 8'(i);
						hit = 1'b1;
						break;
					end
				end
			end
			if (!hit) begin
				if (low_cur >= high_cur) begin
					r.palette_full = 1'b1;
				end else if (fill_start_r) begin
					r.mapped_index = low_cur[7:0];
					pal_model[low_cur[7:0]] = rgb;
					low_cur = low_cur + 9'd1;
					r.was_added = 1'b1;
				end else begin
					high_cur = high_cur - 9'd1;
					r.mapped_index = high_cur[7:0];
					pal_model[high_cur[7:0]] = rgb;
					r.was_added = 1'b1;
				end
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// hold start high until the word is taken, then queue what it should produce
	task automatic send_word(input item_t w, input bit typed, input result_t typed_res);
		result_t predicted;
		start <= 1'b1;
		item  <= w;
		do @(posedge clk); while (busy);
		predicted = predict_mapping(w);
		pending_maps.insert(pending_maps.size(), typed ? typed_res : predicted);
	endtask

	// register write, only once every queued result has come back
	task automatic write_cfg(input logic idx, input logic val);
		start <= 1'b0;
		@(posedge clk);
		while (pending_maps.size() != 0) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_SKIP_ZERO) skip_zero_r = val;
		else fill_start_r = val;
	endtask

	// result checker: every done word against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_maps.size() == 0) begin
				report_mismatch($sformatf("result word %h with nothing expected", result));
			end else begin
				oldest_map = pending_maps.pop_front();
				if (result.mapped_index !== oldest_map.mapped_index)
					report_mismatch($sformatf("mapped_index got %0d expected %0d",
						result.mapped_index, oldest_map.mapped_index));
				if (result.was_added !== oldest_map.was_added)
					report_mismatch($sformatf("was_added got %b expected %b",
						result.was_added, oldest_map.was_added));
				if (result.palette_full !== oldest_map.palette_full)
					report_mismatch($sformatf("palette_full got %b expected %b",
						result.palette_full, oldest_map.palette_full));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_palette_find_or_insert NOT OK");
			$finish;
		end
	end

	initial begin
		item_t       w;
		logic [23:0] rgb;
		int          pick;
		int          idle_pct;
		int          fresh_pct;
		int          reinit_pct;

		// directed rows; expected values given where obvious, the rest from the model
		dir_rows = '{
			// reset state: presets hit, first insert at the low cursor
			'{ROW_ITEM, 1'b0, 1'b0, OP_MAP,    8'd0,   24'h000000, 1'b1, 8'd0,   1'b0, 1'b0},
			'{ROW_ITEM, 1'b0, 1'b0, OP_MAP,    8'd5,   24'hFFFFFF, 1'b1, 8'd15,  1'b0, 1'b0},
			'{ROW_ITEM, 1'b0, 1'b0, OP_MAP,    8'd255, 24'hAB5700, 1'b1, 8'd6,   1'b0, 1'b0},
			'{ROW_ITEM, 1'b0, 1'b0, OP_MAP,    8'h80,  24'h123456, 1'b1, 8'd16,  1'b1, 1'b0},
			'{ROW_ITEM, 1'b0, 1'b0, OP_MAP,    8'h7F,  24'h123456, 1'b1, 8'd16,  1'b0, 1'b0},
			// transparent pixel
			'{ROW_CFG,  CFG_SKIP_ZERO, 1'b1, OP_MAP, 8'd0, 24'h0, 1'b0, 8'd0, 1'b0, 1'b0},
			'{ROW_ITEM, 1'b0, 1'b0, OP_MAP,    8'd0,   24'h123456, 1'b1, 8'd0,   1'b0, 1'b0},
			'{ROW_ITEM, 1'b0, 1'b0, OP_MAP,    8'd1,   24'hFFFFFE, 1'b1, 8'd17,  1'b1, 1'b0},
			// high end: empty region, fills from the top
			'{ROW_CFG,  CFG_FILL_FROM_START, 1'b0, OP_MAP, 8'd0, 24'h0, 1'b0, 8'd0, 1'b0, 1'b0},
			'{ROW_ITEM, 1'b0, 1'b0, OP_MAP,    8'hAA,  24'hFFFFFF, 1'b1, 8'd255, 1'b1, 1'b0},
			'{ROW_ITEM, 1'b0, 1'b0, OP_MAP,    8'h55,  24'hFFFFFF, 1'b1, 8'd255, 1'b0, 1'b0},
			'{ROW_ITEM, 1'b0, 1'b0, OP_MAP,    8'h01,  24'h000001, 1'b0, 8'd0,   1'b0, 1'b0},
			'{ROW_ITEM, 1'b0, 1'b0, OP_MAP,    8'hFE,  24'h123456, 1'b0, 8'd0,   1'b0, 1'b0},
			// reinitialise wins over a transparent pixel
			'{ROW_ITEM, 1'b0, 1'b0, OP_REINIT, 8'd0,   24'hFFFFFF, 1'b1, 8'd0,   1'b0, 1'b0},
			'{ROW_ITEM, 1'b0, 1'b0, OP_MAP,    8'h33,  24'hFFFFFF, 1'b0, 8'd0,   1'b0, 1'b0},
			'{ROW_CFG,  CFG_FILL_FROM_START, 1'b1, OP_MAP, 8'd0, 24'h0, 1'b0, 8'd0, 1'b0, 1'b0},
			'{ROW_ITEM, 1'b0, 1'b0, OP_MAP,    8'hC3,  24'hFFFFFF, 1'b1, 8'd15,  1'b0, 1'b0},
			'{ROW_ITEM, 1'b0, 1'b0, OP_MAP,    8'h3C,  24'h123456, 1'b0, 8'd0,   1'b0, 1'b0},
			'{ROW_CFG,  CFG_SKIP_ZERO, 1'b0, OP_MAP, 8'd0, 24'h0, 1'b0, 8'd0, 1'b0, 1'b0},
			'{ROW_ITEM, 1'b0, 1'b0, OP_MAP,    8'd0,   24'h000000, 1'b1, 8'd0,   1'b0, 1'b0},
			'{ROW_ITEM, 1'b0, 1'b0, OP_REINIT, 8'hFF,  24'h000000, 1'b1, 8'd0,   1'b0, 1'b0}
		};

		restore_presets();
		skip_zero_r  = 1'b0;
		fill_start_r = 1'b1;

		// reset, once
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		foreach (dir_rows[r]) begin
			if (dir_rows[r].kind == ROW_CFG) begin
				write_cfg(dir_rows[r].cfg_idx, dir_rows[r].cfg_val);
			end else begin
				w = {dir_rows[r].op, dir_rows[r].pix, dir_rows[r].rgb};
				send_word(w, dir_rows[r].typed,
					{dir_rows[r].e_idx, dir_rows[r].e_add, dir_rows[r].e_full});
			end
		end

		// random part: early segments fill the palette, later ones mix hits, full and reinit
		for (int seg = 0; seg < SEG_COUNT; seg++) begin
			write_cfg(CFG_SKIP_ZERO, SEG_SKIP[seg]);
			write_cfg(CFG_FILL_FROM_START, SEG_FILL[seg]);
			idle_pct   = (seg < 3) ? 35 : (seg < 6) ? 57 : 0;
			fresh_pct  = (seg < 3) ? 80 : 40;
			reinit_pct = (seg < 3) ? 0 : 2;
			for (int n = 0; n < SEG_WORDS; n++) begin
				// new color, a preset, or one already in the palette
				pick = $urandom_range(99);
				if (pick < fresh_pct) rgb = 24'($urandom);
				else if (pick < fresh_pct + 10) rgb = PRESET_COLORS[$urandom_range(15)];
				else rgb = pal_model[$urandom_range(255)];
				w.op          = ($urandom_range(99) < reinit_pct) ? OP_REINIT : OP_MAP;
				w.pixel_index = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom);
				{w.red, w.green, w.blue} = rgb;
				send_word(w, 1'b0, '0);

				// now and then hold off until the block has answered everything
				if ($urandom_range(99) < 2) begin
					start <= 1'b0;
					@(posedge clk);
					while (pending_maps.size() != 0) @(posedge clk);
				end else if ($urandom_range(99) < idle_pct) begin
					start <= 1'b0;
					do @(posedge clk); while ($urandom_range(99) < idle_pct);
				end
			end
		end

		// drain and settle
		start <= 1'b0;
		@(posedge clk);
		while (pending_maps.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_maps.size() != 0)
			report_mismatch($sformatf("%0d expected words never arrived", pending_maps.size()));

		if (mismatch_count == 0) begin
			$display("tb_palette_find_or_insert OK");
		end else begin
			$display("tb_palette_find_or_insert NOT OK");
		end
		$finish;
	end

endmodule
